// ----- rtl/pitq_pkg.sv -----
`default_nettype none
package pitq_pkg;

  localparam int FRAC_BITS = 8;
  localparam int PT_W      = 24;
  localparam int VC_W      = 16;
  localparam int NUM_EDGES = 4;

  // point minus scaled vertex, one guard bit
  localparam int SCL_W  = VC_W + FRAC_BITS;
  localparam int DIFF_W = ((PT_W > SCL_W) ? PT_W : SCL_W) + 1;
  // vertex minus vertex, integer units
  localparam int D_W    = VC_W + 1;
  localparam int PROD_W = DIFF_W + D_W;

  typedef struct packed {
    logic                     active;
    logic signed [D_W-1:0]    dy;
    logic signed [D_W-1:0]    dx;
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] by;
  } edge_setup_t;

  typedef struct packed {
    logic                     active;
    logic                     dy_pos;
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
  } edge_prod_t;

endpackage
`default_nettype wire

// ----- rtl/point_in_tri_or_quad_test_core.sv -----
`default_nettype none
// Crossing-number hit test of a point against a triangle or a quad.
// Input channel: a transaction is taken at a rising edge with start high
// and busy low. busy is always low, so a new point may be issued in every
// cycle: the throughput is one transaction per clock.
// Triangle edges run 0-1, 1-2, 2-0; quad edges 0-1, 1-3, 3-2, 2-0.
// Result channel: inside_res is shown for one cycle with done high.
// Register stages between a taken point and done high are edge setup
// (straddle test and differences), the per-edge cross multiplies, and the
// compare and parity.
// The receiver cannot stall; every result is shown exactly once.
// Reset clears the valid pipeline, so no result appears for transactions
// that were in flight; the datapath itself is not reset.
module point_in_tri_or_quad_test_core (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  output logic                                  done,
  input  wire logic signed [pitq_pkg::PT_W-1:0] point_x,
  input  wire logic signed [pitq_pkg::PT_W-1:0] point_y,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert0_x,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert0_y,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert1_x,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert1_y,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert2_x,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert2_y,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert3_x,
  input  wire logic signed [pitq_pkg::VC_W-1:0] vert3_y,
  input  wire                                   is_quad,
  output logic                                  inside_res
);

  logic                  accept;
  logic                  v1, v2;
  logic signed [pitq_pkg::VC_W-1:0] e1_to_x, e1_to_y;
  pitq_pkg::edge_setup_t setup [pitq_pkg::NUM_EDGES];
  pitq_pkg::edge_prod_t  prod  [pitq_pkg::NUM_EDGES];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // edge 1 closes on vertex 3 for a quad
  assign e1_to_x = is_quad ? vert3_x : vert2_x;
  assign e1_to_y = is_quad ? vert3_y : vert2_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  pitq_edge_setup u_setup0 (
    .clk(clk), .en(1'b1), .point_x(point_x), .point_y(point_y),
    .from_x(vert0_x), .from_y(vert0_y), .to_x(vert1_x), .to_y(vert1_y),
    .setup(setup[0])
  );

  pitq_edge_setup u_setup1 (
    .clk(clk), .en(1'b1), .point_x(point_x), .point_y(point_y),
    .from_x(vert1_x), .from_y(vert1_y), .to_x(e1_to_x), .to_y(e1_to_y),
    .setup(setup[1])
  );

  pitq_edge_setup u_setup2 (
    .clk(clk), .en(1'b1), .point_x(point_x), .point_y(point_y),
    .from_x(vert2_x), .from_y(vert2_y), .to_x(vert0_x), .to_y(vert0_y),
    .setup(setup[2])
  );

  pitq_edge_setup u_setup3 (
    .clk(clk), .en(is_quad), .point_x(point_x), .point_y(point_y),
    .from_x(vert3_x), .from_y(vert3_y), .to_x(vert2_x), .to_y(vert2_y),
    .setup(setup[3])
  );

  for (genvar g = 0; g < pitq_pkg::NUM_EDGES; g++) begin : g_prod
    pitq_edge_product u_prod (
      .clk  (clk),
      .setup(setup[g]),
      .prod (prod[g])
    );
  end

  pitq_parity u_parity (
    .clk       (clk),
    .rst       (rst),
    .valid     (v2),
    .prod      (prod),
    .done      (done),
    .inside_res(inside_res)
  );

endmodule
`default_nettype wire

// ----- rtl/pitq_edge_setup.sv -----
`default_nettype none
module pitq_edge_setup (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire logic signed [pitq_pkg::PT_W-1:0] point_x,
  input  wire logic signed [pitq_pkg::PT_W-1:0] point_y,
  input  wire logic signed [pitq_pkg::VC_W-1:0] from_x,
  input  wire logic signed [pitq_pkg::VC_W-1:0] from_y,
  input  wire logic signed [pitq_pkg::VC_W-1:0] to_x,
  input  wire logic signed [pitq_pkg::VC_W-1:0] to_y,
  output pitq_pkg::edge_setup_t                 setup
);

  logic signed [pitq_pkg::DIFF_W-1:0] px, py, fxs, fys, tys;
  pitq_pkg::edge_setup_t setup_next;

  always_comb begin
    px  = pitq_pkg::DIFF_W'(point_x);
    py  = pitq_pkg::DIFF_W'(point_y);
    fxs = pitq_pkg::DIFF_W'(from_x) <<< pitq_pkg::FRAC_BITS;
    fys = pitq_pkg::DIFF_W'(from_y) <<< pitq_pkg::FRAC_BITS;
    tys = pitq_pkg::DIFF_W'(to_y) <<< pitq_pkg::FRAC_BITS;
    setup_next.active = en & ((fys > py) != (tys > py));
    setup_next.dy     = pitq_pkg::D_W'(to_y) - pitq_pkg::D_W'(from_y);
    setup_next.dx     = pitq_pkg::D_W'(to_x) - pitq_pkg::D_W'(from_x);
    setup_next.ax     = px - fxs;
    setup_next.by     = py - fys;
  end

  always_ff @(posedge clk) begin
    setup <= setup_next;
  end

endmodule
`default_nettype wire

// ----- rtl/pitq_edge_product.sv -----
`default_nettype none
module pitq_edge_product (
  input  wire                        clk,
  input  wire pitq_pkg::edge_setup_t setup,
  output pitq_pkg::edge_prod_t       prod
);

  pitq_pkg::edge_prod_t prod_next;

  always_comb begin
    prod_next.active = setup.active;
    prod_next.dy_pos = ~setup.dy[pitq_pkg::D_W-1];
    prod_next.lhs    = pitq_pkg::PROD_W'(setup.ax) * pitq_pkg::PROD_W'(setup.dy);
    prod_next.rhs    = pitq_pkg::PROD_W'(setup.dx) * pitq_pkg::PROD_W'(setup.by);
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule
`default_nettype wire

// ----- rtl/pitq_parity.sv -----
`default_nettype none
module pitq_parity (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       valid,
  input  wire pitq_pkg::edge_prod_t prod [pitq_pkg::NUM_EDGES],
  output logic                      done,
  output logic                      inside_res
);

  logic [pitq_pkg::NUM_EDGES-1:0] toggle;

  always_comb begin
    for (int i = 0; i < pitq_pkg::NUM_EDGES; i++) begin
      toggle[i] = prod[i].active &
                  (prod[i].dy_pos ? (prod[i].lhs < prod[i].rhs)
                                  : (prod[i].lhs > prod[i].rhs));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    inside_res <= ^toggle;
  end

endmodule
`default_nettype wire

// ----- tb/tb_point_in_tri_or_quad_test_core.sv -----
`timescale 1ns / 1ps

import pitq_pkg::*;

localparam int TRI_NEXT [3]  = '{1, 2, 0};
localparam int QUAD_NEXT [4] = '{1, 3, 0, 2};

typedef struct {
  logic signed [PT_W-1:0] px;
  logic signed [PT_W-1:0] py;
  logic signed [VC_W-1:0] vx [4];
  logic signed [VC_W-1:0] vy [4];
  logic                   quad;
} query_t;

class hit_scoreboard;
  bit          inside_due [$];
  int unsigned n_checked;
  int unsigned n_errors;

  // crossing-number parity, exact cross-multiply per straddling edge
  function bit crossing_parity(query_t q);
    longint scale, px, py, fx, fy, ty, dx, dy, lhs, rhs;
    int     j, n;
    bit     odd, left;
    scale = longint'(1) << FRAC_BITS;
    px    = longint'(q.px);
    py    = longint'(q.py);
    n     = q.quad ? 4 : 3;
    odd   = 1'b0;
    for (int i = 0; i < n; i++) begin
      j  = q.quad ? QUAD_NEXT[i] : TRI_NEXT[i];
      fx = longint'(q.vx[i]) * scale;
      fy = longint'(q.vy[i]) * scale;
      ty = longint'(q.vy[j]) * scale;
      if ((fy > py) != (ty > py)) begin
        dy   = longint'(q.vy[j]) - longint'(q.vy[i]);
        dx   = longint'(q.vx[j]) - longint'(q.vx[i]);
        lhs  = (px - fx) * dy;
        rhs  = dx * (py - fy);
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) odd = ~odd;
      end
    end
    return odd;
  endfunction

  function void note_query(query_t q);
    inside_due.push_back(crossing_parity(q));
  endfunction

  function void check_result(logic got);
    bit want;
    if (inside_due.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("unexpected result %0b with no transaction pending", got);
    end else begin
      want = inside_due.pop_front();
      if (got !== want) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch on result %0d: expected inside_res %0b, got %0b",
                   n_checked, want, got);
      end
    end
    n_checked++;
  endfunction

  function int pending();
    return inside_due.size();
  endfunction
endclass

module tb_point_in_tri_or_quad_test_core;

  localparam int RANDOM_ITEMS = 1950;
  localparam int S            = 1 << FRAC_BITS;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   start      = 1'b0;
  logic                   busy;
  logic                   done;
  logic signed [PT_W-1:0] point_x    = '0;
  logic signed [PT_W-1:0] point_y    = '0;
  logic signed [VC_W-1:0] vert0_x    = '0;
  logic signed [VC_W-1:0] vert0_y    = '0;
  logic signed [VC_W-1:0] vert1_x    = '0;
  logic signed [VC_W-1:0] vert1_y    = '0;
  logic signed [VC_W-1:0] vert2_x    = '0;
  logic signed [VC_W-1:0] vert2_y    = '0;
  logic signed [VC_W-1:0] vert3_x    = '0;
  logic signed [VC_W-1:0] vert3_y    = '0;
  logic                   is_quad    = 1'b0;
  logic                   inside_res;

  hit_scoreboard sb;

  point_in_tri_or_quad_test_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .point_x    (point_x),
    .point_y    (point_y),
    .vert0_x    (vert0_x),
    .vert0_y    (vert0_y),
    .vert1_x    (vert1_x),
    .vert1_y    (vert1_y),
    .vert2_x    (vert2_x),
    .vert2_y    (vert2_y),
    .vert3_x    (vert3_x),
    .vert3_y    (vert3_y),
    .is_quad    (is_quad),
    .inside_res (inside_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(inside_res);
  end

  function automatic int srand(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic query_t mk_query(int px, int py, int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3, bit quad);
    query_t q;
    q.px    = PT_W'(px);
    q.py    = PT_W'(py);
    q.vx[0] = VC_W'(x0);
    q.vy[0] = VC_W'(y0);
    q.vx[1] = VC_W'(x1);
    q.vy[1] = VC_W'(y1);
    q.vx[2] = VC_W'(x2);
    q.vy[2] = VC_W'(y2);
    q.vx[3] = VC_W'(x3);
    q.vy[3] = VC_W'(y3);
    q.quad  = quad;
    return q;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     sel, lim, k, r, n, sx, sy, ya, yb;
    sel    = $urandom_range(0, 99);
    q.quad = 1'($urandom_range(0, 1));
    n      = q.quad ? 4 : 3;
    if (sel < 10) begin
      q.px = PT_W'($urandom());
      q.py = PT_W'($urandom());
      for (int i = 0; i < 4; i++) begin
        q.vx[i] = VC_W'($urandom());
        q.vy[i] = VC_W'($urandom());
      end
    end else if (sel < 75) begin
      case ($urandom_range(0, 2))
        0:       lim = 4;
        1:       lim = 64;
        default: lim = 2000;
      endcase
      for (int i = 0; i < 4; i++) begin
        q.vx[i] = VC_W'(srand(lim));
        q.vy[i] = VC_W'(srand(lim));
      end
      q.px = PT_W'(srand(lim * S + S - 1));
      q.py = PT_W'(srand(lim * S + S - 1));
      k    = $urandom_range(0, n - 1);
      r    = $urandom_range(0, 9);
      // land on vertex coordinates now and then
      if (r == 0 || r == 2) q.px = PT_W'(int'(q.vx[k]) * S);
      if (r == 1 || r == 2) q.py = PT_W'(int'(q.vy[k]) * S);
    end else if (sel < 90) begin
      sx = 0;
      sy = 0;
      for (int i = 0; i < 4; i++) begin
        q.vx[i] = VC_W'($urandom());
        q.vy[i] = VC_W'($urandom());
        if (i < n) begin
          sx += int'(q.vx[i]) * S;
          sy += int'(q.vy[i]) * S;
        end
      end
      q.px = PT_W'(sx / n + int'($urandom_range(0, S - 1)));
      q.py = PT_W'(sy / n + int'($urandom_range(0, S - 1)));
    end else begin
      // horizontal and degenerate edges
      ya = srand(16);
      yb = ($urandom_range(0, 3) == 0) ? ya : srand(16);
      for (int i = 0; i < 4; i++) begin
        q.vx[i] = VC_W'(srand(16));
        q.vy[i] = VC_W'($urandom_range(0, 1) ? ya : yb);
      end
      q.px = PT_W'(srand(16 * S));
      q.py = PT_W'($urandom_range(0, 1) ? ya * S : srand(16 * S));
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    start   <= 1'b1;
    point_x <= q.px;
    point_y <= q.py;
    vert0_x <= q.vx[0];
    vert0_y <= q.vy[0];
    vert1_x <= q.vx[1];
    vert1_y <= q.vy[1];
    vert2_x <= q.vx[2];
    vert2_y <= q.vy[2];
    vert3_x <= q.vx[3];
    vert3_y <= q.vy[3];
    is_quad <= q.quad;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_query(q);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    case ($urandom_range(0, 3))
      0:       idle(0);
      1:       idle($urandom_range(1, 3));
      default: idle($urandom_range(1, 15));
    endcase
  endtask

  initial begin
    query_t directed [$];
    int     n_sent;
    int     burst;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // triangle, vertex 3 ignored
    directed.push_back(mk_query(2*S, 2*S, 0, 0, 10, 0, 0, 10, -32768, 32767, 0));
    directed.push_back(mk_query(20*S, 20*S, 0, 0, 10, 0, 0, 10, 32767, -32768, 0));
    directed.push_back(mk_query(2*S + 128, 2*S + 1, 0, 0, 10, 0, 0, 10, 5, 5, 0));
    directed.push_back(mk_query(-1, -1, 0, 0, 10, 0, 0, 10, 0, 0, 0));
    // boundary points
    directed.push_back(mk_query(0, 0, 0, 0, 10, 0, 0, 10, 0, 0, 0));
    directed.push_back(mk_query(5*S, 0, 0, 0, 10, 0, 0, 10, 0, 0, 0));
    directed.push_back(mk_query(0, 5*S, 0, 0, 10, 0, 0, 10, 0, 0, 0));
    directed.push_back(mk_query(5*S, 5*S, 0, 0, 10, 0, 0, 10, 0, 0, 0));
    // square quad
    directed.push_back(mk_query(5*S + 128, 5*S + 128, 0, 0, 10, 0, 0, 10, 10, 10, 1));
    directed.push_back(mk_query(-1, 5*S, 0, 0, 10, 0, 0, 10, 10, 10, 1));
    directed.push_back(mk_query(10*S, 10*S, 0, 0, 10, 0, 0, 10, 10, 10, 1));
    // self-crossing quad
    directed.push_back(mk_query(5*S, 2*S, 0, 0, 10, 0, 10, 10, 0, 10, 1));
    directed.push_back(mk_query(2*S, 5*S, 0, 0, 10, 0, 10, 10, 0, 10, 1));
    directed.push_back(mk_query(5*S, 8*S, 0, 0, 10, 0, 10, 10, 0, 10, 1));
    // field extremes
    directed.push_back(mk_query(0, 0, -32768, -32768, 32767, -32768, 0, 32767, 0, 0, 0));
    directed.push_back(mk_query(8388607, 0, -32768, -32768, 32767, -32768, 0, 32767,
                                0, 0, 0));
    directed.push_back(mk_query(-8388608, -8388608, -32768, -32768, 32767, -32768,
                                0, 32767, 0, 0, 0));
    directed.push_back(mk_query(8388607, 8388607, -32768, -32768, 32767, -32768,
                                -32768, 32767, 32767, 32767, 1));
    directed.push_back(mk_query(-8388608, -8388608, -32768, -32768, 32767, -32768,
                                -32768, 32767, 32767, 32767, 1));
    directed.push_back(mk_query(0, 0, -32768, -32768, 32767, -32768,
                                -32768, 32767, 32767, 32767, 1));
    // degenerate and horizontal edges
    directed.push_back(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(mk_query(3*S, 0, 0, 0, 10, 0, 5, 0, 0, 0, 0));
    directed.push_back(mk_query(3*S, 2*S, 0, 0, 10, 0, 10, 4, 0, 4, 1));

    foreach (directed[i]) begin
      send_query(directed[i]);
      idle($urandom_range(0, 2));
    end

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n_sent < RANDOM_ITEMS; k++) begin
        send_query(random_query());
        n_sent++;
      end
      // first few hundred back to back
      if (n_sent > 300) random_gap();
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("** point_in_tri_or_quad_test_core: PASSED **");
    end else begin
      $display("** point_in_tri_or_quad_test_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("** point_in_tri_or_quad_test_core: FAILED **");
    $finish;
  end

endmodule
